>>> rtl/cvs_pkg.sv
`timescale 1ns / 1ps

package cvs_pkg;

  localparam int VALUE_W     = 24;
  localparam int SUM_W       = 37;
  localparam int MAG_W       = 36;
  localparam int SQ_W        = 59;
  localparam int CNT_W       = 13;
  localparam int PROD_W      = 2 * MAG_W;
  localparam int TOTAL_W     = 63;
  localparam int QUEUE_DEPTH = 4;

  // one closed column, handed from the front to the back
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [SQ_W-1:0]  square_sum;
    logic [CNT_W-1:0] count;
    logic             row_ovf;
    logic             last_matrix;
  } col_rec_t;

endpackage

>>> rtl/cvs_front.sv
`timescale 1ns / 1ps

module cvs_front #(
  parameter int MAX_ROWS = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [23:0]      s_tdata,
  input  logic [1:0]       s_tuser,
  input  logic             s_tlast,
  output logic             push,
  output cvs_pkg::col_rec_t push_rec,
  input  logic             full
);
  import cvs_pkg::*;

  localparam logic [CNT_W-1:0] ROW_LIMIT = CNT_W'(MAX_ROWS);

  logic signed [SUM_W-1:0]     column_sum;
  logic [SQ_W-1:0]             column_square_sum;
  logic [CNT_W-1:0]            present_count;
  logic [CNT_W-1:0]            row_count;
  logic                        row_ovf;

  logic signed [VALUE_W-1:0]   value;
  logic signed [2*VALUE_W-1:0] value_sq;
  logic                        accept;
  logic                        over;
  logic                        take;
  logic                        close;
  logic signed [SUM_W-1:0]     sum_next;
  logic signed [SUM_W-1:0]     sum_neg;
  logic [SQ_W-1:0]             square_next;
  logic [CNT_W-1:0]            present_next;
  logic [CNT_W-1:0]            row_next;
  logic                        row_ovf_next;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;
  assign value    = signed'(s_tdata[VALUE_W-1:0]);
  assign value_sq = value * value;
  assign over     = row_count >= ROW_LIMIT;
  assign take     = !over && !s_tuser[0];
  assign close    = s_tuser[1] || s_tlast;

  always_comb begin
    sum_next     = column_sum + (take ? SUM_W'(value) : '0);
    square_next  = column_square_sum + (take ? SQ_W'($unsigned(value_sq)) : '0);
    present_next = present_count + (take ? CNT_W'(1) : '0);
    row_next     = over ? row_count : row_count + CNT_W'(1);
    row_ovf_next = row_ovf || over;
    sum_neg      = -sum_next;
  end

  always_comb begin
    push                 = accept && close;
    push_rec.mag         = sum_next[SUM_W-1] ? MAG_W'(sum_neg) : MAG_W'(sum_next);
    push_rec.square_sum  = square_next;
    push_rec.count       = present_next;
    push_rec.row_ovf     = row_ovf_next;
    push_rec.last_matrix = s_tlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_sum        <= '0;
      column_square_sum <= '0;
      present_count     <= '0;
      row_count         <= '0;
      row_ovf           <= 1'b0;
    end else if (accept) begin
      if (close) begin
        column_sum        <= '0;
        column_square_sum <= '0;
        present_count     <= '0;
        row_count         <= '0;
        row_ovf           <= 1'b0;
      end else begin
        column_sum        <= sum_next;
        column_square_sum <= square_next;
        present_count     <= present_next;
        row_count         <= row_next;
        row_ovf           <= row_ovf_next;
      end
    end
  end

endmodule

>>> rtl/cvs_queue.sv
`timescale 1ns / 1ps

module cvs_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cvs_pkg::col_rec_t push_rec,
  output logic              full,
  input  logic              pop,
  output cvs_pkg::col_rec_t pop_rec,
  output logic              empty
);
  import cvs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  col_rec_t         mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full    = count == (PTR_W + 1)'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign pop_rec = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue read while empty");
`endif

endmodule

>>> rtl/cvs_back.sv
`timescale 1ns / 1ps

module cvs_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  cvs_pkg::col_rec_t pop_rec,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [63:0]       m_tdata,
  output logic              m_tuser
);
  import cvs_pkg::*;

  localparam int STEP_W = $clog2(PROD_W);

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_ACC} state_t;

  state_t              state;
  col_rec_t            rec;
  logic [PROD_W-1:0]   acc;
  logic [MAG_W-1:0]    mplier;
  logic [CNT_W-1:0]    rem;
  logic [STEP_W-1:0]   step;
  logic [TOTAL_W-1:0]  total;
  logic                ovf;
  logic [TOTAL_W-1:0]  out_total;
  logic                out_ovf;

  logic [PROD_W-1:0]   mul_next;
  logic [CNT_W:0]      rem_shift;
  logic [CNT_W:0]      rem_diff;
  logic                fits;
  logic [CNT_W-1:0]    rem_next;
  logic [SQ_W-1:0]     part;
  logic [SQ_W-1:0]     dev;
  logic [TOTAL_W:0]    total_sum;
  logic                sat;
  logic [TOTAL_W-1:0]  total_next;
  logic                ovf_next;

  assign pop      = (state == ST_IDLE) && !empty && !m_tvalid;
  assign m_tdata  = {1'b0, out_total};
  assign m_tuser  = out_ovf;

  always_comb begin
    // square: shift-add, multiplier bit MSB first
    mul_next   = {acc[PROD_W-2:0], 1'b0} + (mplier[MAG_W-1] ? PROD_W'(rec.mag) : '0);
    // restoring division by the present count, quotient shifts into acc
    rem_shift  = {rem, acc[PROD_W-1]};
    rem_diff   = rem_shift - {1'b0, rec.count};
    fits       = rem_shift >= {1'b0, rec.count};
    rem_next   = fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
    part       = acc[SQ_W-1:0];
    dev        = (rec.square_sum >= part) ? rec.square_sum - part : '0;
    total_sum  = {1'b0, total} + (TOTAL_W + 1)'(dev);
    sat        = total_sum[TOTAL_W];
    total_next = sat ? '1 : total_sum[TOTAL_W-1:0];
    ovf_next   = ovf || sat || rec.row_ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      total    <= '0;
      ovf      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            rec    <= pop_rec;
            acc    <= '0;
            mplier <= pop_rec.mag;
            rem    <= '0;
            step   <= STEP_W'(MAG_W - 1);
            state  <= (pop_rec.count == '0) ? ST_ACC : ST_MUL;
          end
        end
        ST_MUL: begin
          acc    <= mul_next;
          mplier <= {mplier[MAG_W-2:0], 1'b0};
          if (step == '0) begin
            step  <= STEP_W'(PROD_W - 1);
            state <= ST_DIV;
          end else begin
            step <= step - STEP_W'(1);
          end
        end
        ST_DIV: begin
          rem <= rem_next;
          acc <= {acc[PROD_W-2:0], fits};
          if (step == '0) begin
            state <= ST_ACC;
          end else begin
            step <= step - STEP_W'(1);
          end
        end
        ST_ACC: begin
          if (rec.last_matrix) begin
            out_total <= total_next;
            out_ovf   <= ovf_next;
            m_tvalid  <= 1'b1;
            total     <= '0;
            ovf       <= 1'b0;
          end else begin
            total <= total_next;
            ovf   <= ovf_next;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_rem_below_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < rec.count)
    else $error("division remainder not below count");
  a_result_from_acc: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_ACC && $past(rec.last_matrix))
    else $error("result raised outside a matrix close");
  a_mul_to_div: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL && step == '0 |=> state == ST_DIV)
    else $error("square step did not hand over to division");
`endif

endmodule

>>> rtl/column_variance_sum_top.sv
`timescale 1ns / 1ps

// Sum of squared deviations per column. Elements stream in column by column, one
// beat per cycle, as long as the column queue has room. Each column end pushes a
// record (|sum|, sum of squares, present count) into a 4-entry queue; the back end
// squares |sum| with a shift-add unit, divides by the count with a restoring
// divider and adds the deviation to the matrix total. It takes one column at a
// time, popping the next only when done with the last (an all-missing column
// skips the square and the division). Input runs at full rate while the back end
// keeps up or the queue absorbs the burst. The result beat comes out after the
// last column of a matrix is processed and holds until taken; the total saturates
// at 2^63-1 and sets the overflow flag, as does any element past MAX_ROWS in a
// column (that element is dropped).
module column_variance_sum_top #(
  parameter int MAX_ROWS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // sample_value
  input  logic [1:0]  s_tuser,   // sample_missing, end_of_column
  input  logic        s_tlast,   // end_of_matrix
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // heterogeneity
  output logic        m_tuser    // overflowed
);
  import cvs_pkg::*;

  col_rec_t push_rec;
  col_rec_t pop_rec;
  logic     push;
  logic     pop;
  logic     full;
  logic     empty;

  cvs_front #(
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .push     (push),
    .push_rec (push_rec),
    .full     (full)
  );

  cvs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (full),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .empty    (empty)
  );

  cvs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop_rec  (pop_rec),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import cvs_pkg::*;

  localparam int MAX_ROWS      = 4096;
  localparam int WATCHDOG_MAX  = 20000;
  localparam int SETTLE_CYCLES = 300;
  localparam logic [63:0] TOTAL_CEIL = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [TOTAL_W-1:0] heterogeneity;
    logic               overflowed;
  } matrix_result_t;

  class deviation_scoreboard;
    longint         col_sum;
    logic [63:0]    col_square_sum;
    int             present_cnt;
    int             row_cnt;
    logic [63:0]    total;
    logic           ovf_seen;
    matrix_result_t expected_q[$];
    int             errors;

    function new();
      col_sum        = 0;
      col_square_sum = '0;
      present_cnt    = 0;
      row_cnt        = 0;
      total          = '0;
      ovf_seen       = 1'b0;
      errors         = 0;
    endfunction

    function void close_column();
      logic [71:0] mag;
      logic [71:0] part;
      logic [63:0] dev;
      logic [64:0] acc;
      if (present_cnt > 0) begin
        mag  = (col_sum < 0) ? 72'(-col_sum) : 72'(col_sum);
        part = (mag * mag) / 72'(present_cnt);
        dev  = (72'(col_square_sum) >= part) ? col_square_sum - part[63:0] : 64'd0;
        acc  = {1'b0, total} + {1'b0, dev};
        if (acc > {1'b0, TOTAL_CEIL}) begin
          total    = TOTAL_CEIL;
          ovf_seen = 1'b1;
        end else begin
          total = acc[63:0];
        end
      end
      col_sum        = 0;
      col_square_sum = '0;
      present_cnt    = 0;
      row_cnt        = 0;
    endfunction

    function void note_input(logic [VALUE_W-1:0] value, logic missing, logic eoc, logic eom);
      longint         v;
      matrix_result_t r;
      if (row_cnt >= MAX_ROWS) begin
        ovf_seen = 1'b1;
      end else begin
        row_cnt++;
        if (!missing) begin
          v = $signed(value);
          col_sum        += v;
          col_square_sum += 64'(v * v);
          present_cnt++;
        end
      end
      if (eoc || eom) close_column();
      if (eom) begin
        r.heterogeneity = total[TOTAL_W-1:0];
        r.overflowed    = ovf_seen;
        expected_q.push_back(r);
        total    = '0;
        ovf_seen = 1'b0;
      end
    endfunction

    function void check_result(logic [63:0] data, logic ovf);
      matrix_result_t r;
      if (expected_q.size() == 0) begin
        $error("result beat with no matrix pending: heterogeneity %0d", data[TOTAL_W-1:0]);
        errors++;
      end else begin
        r = expected_q.pop_front();
        if (data[TOTAL_W-1:0] !== r.heterogeneity) begin
          $error("heterogeneity: expected %0d, actual %0d", r.heterogeneity,
                 data[TOTAL_W-1:0]);
          errors++;
        end
        if (ovf !== r.overflowed) begin
          $error("overflowed: expected %0b, actual %0b", r.overflowed, ovf);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;   // sample_value
  logic [1:0]  s_tuser  = '0;   // sample_missing, end_of_column
  logic        s_tlast  = 1'b0; // end_of_matrix
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;         // heterogeneity
  logic        m_tuser;         // overflowed

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int idle_cnt    = 0;
  int sent_cnt    = 0;

  deviation_scoreboard sb = new();

  column_variance_sum_top #(.MAX_ROWS(MAX_ROWS)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // inputs only change at the rising edge, so the falling edge sees what the next
  // rising edge will take
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_input(s_tdata, s_tuser[0], s_tuser[1], s_tlast);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cnt = 0;
      end else begin
        idle_cnt++;
        if (idle_cnt >= WATCHDOG_MAX) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  task automatic send_beat(logic [23:0] value, logic missing, logic eoc, logic eom);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= {eoc, missing};
    s_tlast  <= eom;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    sent_cnt++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [23:0] pick_value();
    case ($urandom_range(5))
      0:       return 24'h800000;
      1:       return 24'h7FFFFF;
      2:       return 24'($signed($urandom_range(64)) - 32);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_random_matrix();
    int   ncols;
    int   nrows;
    logic all_missing;
    logic last_col;
    logic last_row;
    ncols = $urandom_range(1, 4);
    for (int c = 0; c < ncols; c++) begin
      nrows       = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      all_missing = ($urandom_range(9) == 0);
      last_col    = (c == ncols - 1);
      for (int r = 0; r < nrows; r++) begin
        last_row = (r == nrows - 1);
        send_beat(pick_value(), all_missing || ($urandom_range(4) == 0),
                  last_row && (!last_col || $urandom_range(1)), last_row && last_col);
      end
    end
  endtask

  task automatic send_random(int items);
    int stop_at;
    stop_at = sent_cnt + items;
    while (sent_cnt < stop_at) send_random_matrix();
  endtask

  task automatic send_directed();
    send_beat(24'h7FFFFF, 1'b0, 1'b1, 1'b1);
    send_beat(24'h123456, 1'b1, 1'b0, 1'b1);
    send_beat(24'h7FFFFF, 1'b0, 1'b0, 1'b0);
    send_beat(24'h800000, 1'b0, 1'b1, 1'b0);
    send_beat(24'h7FFFFF, 1'b1, 1'b0, 1'b0);
    send_beat(24'h800000, 1'b1, 1'b1, 1'b0);
    send_beat(24'h000000, 1'b0, 1'b0, 1'b0);
    send_beat(24'hFFFFFF, 1'b0, 1'b0, 1'b0);
    send_beat(24'h000001, 1'b0, 1'b0, 1'b1);
    send_beat(24'h800000, 1'b0, 1'b0, 1'b0);
    send_beat(24'hAAAAAA, 1'b1, 1'b0, 1'b0);
    send_beat(24'h800000, 1'b0, 1'b0, 1'b0);
    send_beat(24'h7FFFFF, 1'b0, 1'b0, 1'b0);
    send_beat(24'h555555, 1'b1, 1'b0, 1'b0);
    send_beat(24'h7FFFFF, 1'b0, 1'b1, 1'b1);
    send_beat(24'h000000, 1'b1, 1'b1, 1'b0);
    send_beat(24'h001000, 1'b0, 1'b1, 1'b0);
    send_beat(24'hFFF000, 1'b0, 1'b1, 1'b1);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 27;
    rx_idle_pct = 77;
    send_directed();
    send_random(460);
    drain();
    tx_idle_pct = 77;
    rx_idle_pct = 27;
    send_random(470);
    drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(470);
    drain();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/cvs_pkg.sv
rtl/cvs_front.sv
rtl/cvs_queue.sv
rtl/cvs_back.sv
rtl/column_variance_sum_top.sv
tb/tb.sv
